FILE: src/gppf_pkg.sv
// Shared types, codes and constants of the general-position point filter.
package gppf_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_BITS_DEF = 8;

    localparam int          TARGET_W     = 5;
    localparam logic [4:0]  TARGET_RESET = 5'd12;

    // Result word layout, lowest bit first
    localparam int STATUS_W     = 3;
    localparam int OUT_COUNT_W  = 5;
    localparam int OUT_PAD_W    = 7;
    localparam int OUT_DATA_W   = STATUS_W + OUT_COUNT_W + 1 + OUT_PAD_W;
    localparam int COUNT_LSB    = STATUS_W;
    localparam int COMPLETE_BIT = STATUS_W + OUT_COUNT_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_COLLINEAR = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_CLEARED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DUP,
        S_PAIR,
        S_DRAIN,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // latch the incoming word
        logic    clr_flags;  // reset the hit flags
        logic    rd_en;      // issue one memory read into the check pipeline
        logic    rd_pair;    // 1: pair area check, 0: duplicate check
        logic    commit;     // store the candidate, bump the count
        logic    clear;      // empty the set
        logic    out_load;   // load the result register
        status_t code;       // result code to load
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cand_clr;
        logic full;
        logic busy;
        logic dup_hit;
        logic col_hit;
        logic out_free;
    } ctrl_stat_t;

endpackage

FILE: src/gppf_ctrl.sv
// Sequencer of the point filter: walks the duplicate scan and the pair scan.
module gppf_ctrl
    import gppf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CNT_W-1:0]  count,
    input  ctrl_stat_t        stat,
    output ctrl_cmd_t         cmd,
    output logic [ADDR_W-1:0] rd_a,
    output logic [ADDR_W-1:0] rd_b
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    status_t          result_reg, result_next;
    status_t          final_code;
    logic             dup_more;
    logic             pair_more;

    assign dup_more  = i_reg < count;
    assign pair_more = j_reg < count;
    assign rd_a      = i_reg[ADDR_W-1:0];
    assign rd_b      = j_reg[ADDR_W-1:0];

    // Duplicate wins over collinear; clear and full never raise a flag.
    always_comb begin
        if (result_reg == ST_ACCEPTED && stat.dup_hit) begin
            final_code = ST_DUPLICATE;
        end else if (result_reg == ST_ACCEPTED && stat.col_hit) begin
            final_code = ST_COLLINEAR;
        end else begin
            final_code = result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            result_reg <= ST_ACCEPTED;
        end else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            result_reg <= result_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.cand_clr || stat.full) state_next = S_DONE;
                else state_next = S_DUP;
            end
            S_DUP: begin
                if (!dup_more) state_next = S_PAIR;
            end
            S_PAIR: begin
                if (!pair_more) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!stat.busy) state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        cmd.code = final_code;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECIDE: begin
                cmd.clr_flags = 1'b1;
            end
            S_DUP: begin
                cmd.rd_en = dup_more;
            end
            S_PAIR: begin
                cmd.rd_en   = pair_more;
                cmd.rd_pair = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                cmd.out_load = stat.out_free;
                cmd.commit   = stat.out_free && final_code == ST_ACCEPTED;
                cmd.clear    = stat.out_free && final_code == ST_CLEARED;
            end
            default: begin
            end
        endcase
    end

    // Scan indexes and provisional result
    always_comb begin
        i_next      = i_reg;
        j_next      = j_reg;
        result_next = result_reg;
        case (state_reg)
            S_DECIDE: begin
                i_next = '0;
                if (stat.cand_clr) result_next = ST_CLEARED;
                else if (stat.full) result_next = ST_FULL;
                else result_next = ST_ACCEPTED;
            end
            S_DUP: begin
                if (dup_more) begin
                    i_next = CNT_W'(i_reg + 1'b1);
                end else begin
                    i_next = '0;
                    j_next = CNT_W'(1);
                end
            end
            S_PAIR: begin
                if (pair_more) begin
                    if (CNT_W'(j_reg + 1'b1) < count) begin
                        j_next = CNT_W'(j_reg + 1'b1);
                    end else begin
                        i_next = CNT_W'(i_reg + 1'b1);
                        j_next = CNT_W'(i_reg + 2'd2);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/gppf_dp.sv
// Datapath of the point filter: point store, check pipeline, count and result register.
module gppf_dp
    import gppf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic                  in_clr,
    input  logic                  cfg_valid,
    input  logic [TARGET_W-1:0]   cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output status_t               out_status,
    output logic [OUT_COUNT_W-1:0] out_count,
    output logic                  out_complete,
    input  ctrl_cmd_t             cmd,
    input  logic [ADDR_W-1:0]     rd_a,
    input  logic [ADDR_W-1:0]     rd_b,
    output ctrl_stat_t            stat,
    output logic [CNT_W-1:0]      count
);

    localparam int CMP_W  = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
    // |area| stays below 2^(2*COORD_BITS), so the product width holds the sum
    localparam int PROD_W = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

    logic [TARGET_W-1:0]   target_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COORD_BITS-1:0] cand_x_reg, cand_y_reg;
    logic                  cand_clr_reg;

    logic [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic                  v1_reg, pair1_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic                  eq2_reg, v2_reg, pair2_reg;
    logic                  dup_hit_reg, col_hit_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic                  out_complete_reg;

    logic [CMP_W-1:0]      eff_target, target_ext, max_ext, count_ext, next_ext;
    logic                  out_free;

    logic signed [COORD_BITS:0] xs, x1s, x2s, ys, y1s, y2s;
    logic signed [PROD_W-1:0]   area;

    assign target_ext = CMP_W'(target_reg);
    assign max_ext    = CMP_W'(MAX_POINTS);
    assign eff_target = (target_ext > max_ext) ? max_ext : target_ext;
    assign count_ext  = CMP_W'(count_reg);

    always_comb begin
        if (cmd.clear) count_next = '0;
        else if (cmd.commit) count_next = CNT_W'(count_reg + 1'b1);
        else count_next = count_reg;
    end
    assign next_ext = CMP_W'(count_next);

    assign out_free = !out_valid_reg || out_ready;

    assign stat.cand_clr = cand_clr_reg;
    assign stat.full     = count_ext >= eff_target;
    assign stat.busy     = v1_reg || v2_reg;
    assign stat.dup_hit  = dup_hit_reg;
    assign stat.col_hit  = col_hit_reg;
    assign stat.out_free = out_free;
    assign count         = count_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RESET;
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            dup_hit_reg   <= 1'b0;
            col_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) target_reg <= cfg_data;
            count_reg <= count_next;
            v1_reg    <= cmd.rd_en;
            v2_reg    <= v1_reg;
            if (cmd.clr_flags) begin
                dup_hit_reg <= 1'b0;
                col_hit_reg <= 1'b0;
            end else if (v2_reg) begin
                if (!pair2_reg && eq2_reg) dup_hit_reg <= 1'b1;
                if (pair2_reg && area == '0) col_hit_reg <= 1'b1;
            end
            if (cmd.out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Candidate latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_x_reg   <= in_x;
            cand_y_reg   <= in_y;
            cand_clr_reg <= in_clr;
        end
    end

    // Point store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem_x[count_reg[ADDR_W-1:0]] <= cand_x_reg;
            mem_y[count_reg[ADDR_W-1:0]] <= cand_y_reg;
        end
        if (cmd.rd_en) begin
            ax_reg <= mem_x[rd_a];
            ay_reg <= mem_y[rd_a];
            bx_reg <= mem_x[rd_b];
            by_reg <= mem_y[rd_b];
        end
        pair1_reg <= cmd.rd_pair;
    end

    assign xs  = $signed({1'b0, cand_x_reg});
    assign ys  = $signed({1'b0, cand_y_reg});
    assign x1s = $signed({1'b0, ax_reg});
    assign y1s = $signed({1'b0, ay_reg});
    assign x2s = $signed({1'b0, bx_reg});
    assign y2s = $signed({1'b0, by_reg});

    // Registered products of x*(y1-y2) + x1*(y2-y) + x2*(y-y1); their sum is combinational
    always_ff @(posedge aclk) begin
        p0_reg    <= PROD_W'(xs)  * (PROD_W'(y1s) - PROD_W'(y2s));
        p1_reg    <= PROD_W'(x1s) * (PROD_W'(y2s) - PROD_W'(ys));
        p2_reg    <= PROD_W'(x2s) * (PROD_W'(ys) - PROD_W'(y1s));
        eq2_reg   <= (ax_reg == cand_x_reg) && (ay_reg == cand_y_reg);
        pair2_reg <= pair1_reg;
    end

    assign area = p0_reg + p1_reg + p2_reg;

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg   <= cmd.code;
            out_count_reg    <= next_ext[OUT_COUNT_W-1:0];
            out_complete_reg <= next_ext >= eff_target;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_count    = out_count_reg;
    assign out_complete = out_complete_reg;

endmodule

FILE: src/general_position_point_filter.sv
// Top level of the general-position point filter.
//
//  channel | direction | words                                | fields, lowest bit first
//  s_      | in        | one candidate point or clear request | s_tdata: point_x, point_y
//          |           |                                      | s_tuser: clear_set
//  m_      | out       | one result per input word            | m_tdata: status, point_count,
//          |           |                                      |          set_complete, pad
//  cfg_    | in        | target_count write                   | cfg_data: target_count
//
// Scans: a clear or a refusal as full skips both scans; a candidate is checked by the
// duplicate scan over the stored points and the pair scan over every pair of them,
// which read the point store one point or one pair per cycle into a three-stage area
// pipeline.
// Reset: aresetn low clears the count, the result valid flag and the sequencer, and sets
// target_count to 12. The point store needs no clearing pass.
// Stalls: a result waits in the output register while m_tready is low; the next word is
// accepted meanwhile and held at its last step until the register frees.
module general_position_point_filter
    import gppf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W   = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // point_x, point_y, zero pad
    input  logic                  s_tuser,   // clear_set
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status, point_count, set_complete, zero pad
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TARGET_W-1:0]   cfg_data   // target_count
);

    ctrl_cmd_t              cmd;
    ctrl_stat_t             stat;
    logic [CNT_W-1:0]       count;
    logic [ADDR_W-1:0]      rd_a, rd_b;
    status_t                out_status;
    logic [OUT_COUNT_W-1:0] out_count;
    logic                   out_complete;

    // Take target writes at any time; the user is to write them only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    gppf_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .count   (count),
        .stat    (stat),
        .cmd     (cmd),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    gppf_dp #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_x        (s_tdata[COORD_BITS-1:0]),
        .in_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_clr      (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_count   (out_count),
        .out_complete(out_complete),
        .cmd         (cmd),
        .rd_a        (rd_a),
        .rd_b        (rd_b),
        .stat        (stat),
        .count       (count)
    );

    // Pack the result word
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_complete, out_count, out_status};

endmodule

FILE: src/gppf_checker.sv
// Port-level checks of the point filter and their binding to the top level.
module gppf_checker
    import gppf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0]    st;
    logic [OUT_COUNT_W-1:0] cnt;
    logic                   done;

    assign st   = m_tdata[STATUS_W-1:0];
    assign cnt  = m_tdata[COUNT_LSB +: OUT_COUNT_W];
    assign done = m_tdata[COMPLETE_BIT];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st == ST_ACCEPTED || st == ST_COLLINEAR || st == ST_DUPLICATE
                     || st == ST_FULL || st == ST_CLEARED)
        else $error("undefined status code");

    a_full_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_FULL |-> done)
        else $error("full refusal without set_complete");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_CLEARED |-> cnt == '0)
        else $error("clear left points in the set");

endmodule

bind general_position_point_filter gppf_checker u_gppf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: tb/general_position_point_filter_tb.sv
// Self-checking testbench for the general-position point filter.
`timescale 1ns / 1ps

module general_position_point_filter_tb
    import gppf_pkg::*;
();

    localparam int SET_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 140;   // a full pair scan at fifteen stored points, plus margin

    typedef struct packed {
        status_t    status;
        logic [4:0] count;
        logic       complete;
    } filter_result_t;

    typedef enum logic [1:0] {
        ROW_POINT,
        ROW_CLEAR,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [7:0]     x;
        logic [7:0]     y;
        logic [4:0]     cfg;
        logic           typed;
        filter_result_t want;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;   // point_x, point_y
    logic                  s_tuser = 1'b0; // clear_set
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // status, point_count, set_complete, pad
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TARGET_W-1:0]   cfg_data = '0;  // target_count

    general_position_point_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the point set and the target register
    logic [7:0]     pts_x [SET_DEPTH];
    logic [7:0]     pts_y [SET_DEPTH];
    int             set_count  = 0;
    int             set_target = int'(TARGET_RESET);
    filter_result_t expected_results [$];
    int             mismatch_count = 0;
    bit             quiet = 1'b0;
    bit             hold_req = 1'b0;
    int             ox = 0;
    int             oy = 0;

    // Directed script; typed rows carry their result, untyped point rows go through the predictor
    localparam int NUM_ROWS = 30;
    script_row_t script [NUM_ROWS] = '{
        '{ROW_POINT, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd1, 1'b0}},
        '{ROW_POINT, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_DUPLICATE, 5'd1, 1'b0}},
        '{ROW_POINT, 8'd255, 8'd255, 5'd0,  1'b1, '{ST_ACCEPTED,  5'd2, 1'b0}},
        '{ROW_POINT, 8'd128, 8'd128, 5'd0,  1'b1, '{ST_COLLINEAR, 5'd2, 1'b0}},
        '{ROW_POINT, 8'd255, 8'd0,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd3, 1'b0}},
        '{ROW_POINT, 8'd0,   8'd255, 5'd0,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd255, 8'd0,   5'd0,  1'b1, '{ST_DUPLICATE, 5'd4, 1'b0}},
        '{ROW_POINT, 8'd170, 8'd85,  5'd0,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd85,  8'd171, 5'd0,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_CLEAR, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_CLEARED,   5'd0, 1'b0}},
        '{ROW_CFG,   8'd0,   8'd0,   5'd1,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd3,   8'd4,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd1, 1'b1}},
        '{ROW_POINT, 8'd3,   8'd4,   5'd0,  1'b1, '{ST_FULL,      5'd1, 1'b1}},
        '{ROW_POINT, 8'd200, 8'd7,   5'd0,  1'b1, '{ST_FULL,      5'd1, 1'b1}},
        '{ROW_CFG,   8'd0,   8'd0,   5'd0,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd9,   8'd9,   5'd0,  1'b1, '{ST_FULL,      5'd1, 1'b1}},
        '{ROW_CLEAR, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_CLEARED,   5'd0, 1'b1}},
        '{ROW_POINT, 8'd9,   8'd9,   5'd0,  1'b1, '{ST_FULL,      5'd0, 1'b1}},
        '{ROW_CFG,   8'd0,   8'd0,   5'd3,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd1, 1'b0}},
        '{ROW_POINT, 8'd1,   8'd1,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd2, 1'b0}},
        '{ROW_POINT, 8'd2,   8'd2,   5'd0,  1'b1, '{ST_COLLINEAR, 5'd2, 1'b0}},
        '{ROW_POINT, 8'd1,   8'd1,   5'd0,  1'b1, '{ST_DUPLICATE, 5'd2, 1'b0}},
        '{ROW_POINT, 8'd2,   8'd4,   5'd0,  1'b1, '{ST_ACCEPTED,  5'd3, 1'b1}},
        '{ROW_POINT, 8'd5,   8'd5,   5'd0,  1'b1, '{ST_FULL,      5'd3, 1'b1}},
        '{ROW_CFG,   8'd0,   8'd0,   5'd2,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd7,   8'd1,   5'd0,  1'b1, '{ST_FULL,      5'd3, 1'b1}},
        '{ROW_CFG,   8'd0,   8'd0,   5'd31, 1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_POINT, 8'd7,   8'd1,   5'd0,  1'b0, '{ST_ACCEPTED,  5'd0, 1'b0}},
        '{ROW_CLEAR, 8'd0,   8'd0,   5'd0,  1'b1, '{ST_CLEARED,   5'd0, 1'b0}}
    };

    // Apply one word to the shadow set and return the result it must produce
    function automatic filter_result_t filter_point(input logic clr,
                                                    input logic [7:0] px, input logic [7:0] py);
        filter_result_t r;
        int             lim;
        int             n;
        int             xi, yi, x1, y1, x2, y2;
        lim = (set_target > SET_DEPTH) ? SET_DEPTH : set_target;
        n   = set_count;
        xi  = int'(px);
        yi  = int'(py);
        if (clr) begin
            set_count = 0;
            r.status  = ST_CLEARED;
        end else if (n >= lim) begin
            r.status = ST_FULL;
        end else begin
            r.status = ST_ACCEPTED;
            for (int i = 0; i < n; i++)
                if (pts_x[i] == px && pts_y[i] == py)
                    r.status = ST_DUPLICATE;
            if (r.status == ST_ACCEPTED) begin
                for (int i = 0; i < n; i++) begin
                    for (int j = i + 1; j < n; j++) begin
                        x1 = int'(pts_x[i]);
                        y1 = int'(pts_y[i]);
                        x2 = int'(pts_x[j]);
                        y2 = int'(pts_y[j]);
                        if (xi * (y1 - y2) + x1 * (y2 - yi) + x2 * (yi - y1) == 0)
                            r.status = ST_COLLINEAR;
                    end
                end
            end
            if (r.status == ST_ACCEPTED) begin
                pts_x[n]  = px;
                pts_y[n]  = py;
                set_count = n + 1;
            end
        end
        r.count    = set_count[4:0];
        r.complete = (set_count >= lim);
        return r;
    endfunction

    // Offer one word, wait for it to be taken, then log its expected result
    task automatic send_word(input logic clr, input logic [7:0] px, input logic [7:0] py,
                             input logic typed, input filter_result_t typed_res);
        filter_result_t r;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = filter_point(clr, px, py);
        expected_results = {expected_results, (typed ? typed_res : r)};
    endtask

    // Drop the input valid and hold until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_target(input logic [4:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        set_target = int'(value);
    endtask

    // Mostly points that can build a set, with duplicates, collinear picks and stray clears
    task automatic pick_candidate(output logic clr, output logic [7:0] px, output logic [7:0] py);
        int mode, i, j, k, t, cx, cy, x1, y1, x2, y2;
        mode = $urandom_range(0, 19);
        clr  = 1'b0;
        px   = 8'($urandom_range(0, 255));
        py   = 8'($urandom_range(0, 255));
        if (mode == 19) begin
            clr = 1'b1;
        end else if (mode >= 14 && mode <= 16) begin
            // points on a parabola never have three on one line
            k  = $urandom_range(0, 15);
            px = 8'(k + ox);
            py = 8'(k * k + oy);
        end else if (mode == 17 && set_count > 0) begin
            i  = $urandom_range(0, set_count - 1);
            px = pts_x[i];
            py = pts_y[i];
        end else if (mode == 18 && set_count >= 2) begin
            i = $urandom_range(0, set_count - 1);
            j = $urandom_range(0, set_count - 2);
            if (j >= i)
                j++;
            t  = int'($urandom_range(0, 4)) - 1;
            x1 = int'(pts_x[i]);
            y1 = int'(pts_y[i]);
            x2 = int'(pts_x[j]);
            y2 = int'(pts_y[j]);
            cx = x1 + t * (x2 - x1);
            cy = y1 + t * (y2 - y1);
            if (cx >= 0 && cx <= 255 && cy >= 0 && cy <= 255) begin
                px = 8'(cx);
                py = 8'(cy);
            end else begin
                px = 8'($urandom_range(0, 7));
                py = 8'($urandom_range(0, 7));
            end
        end else if (mode >= 11 && mode <= 13) begin
            px = 8'($urandom_range(0, 7));
            py = 8'($urandom_range(0, 7));
        end
    endtask

    function automatic logic [4:0] pick_target();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'd12;
            default: return 5'($urandom_range(2, 17));
        endcase
    endfunction

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        filter_result_t want;
        status_t        got_status;
        logic [4:0]     got_count;
        logic           got_complete;
        got_status   = status_t'(word[STATUS_W-1:0]);
        got_count    = word[COUNT_LSB +: OUT_COUNT_W];
        got_complete = word[COMPLETE_BIT];
        if (expected_results.size() == 0) begin
            $error("result word %h with nothing outstanding", word);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                mismatch_count++;
            end
            if (got_count !== want.count) begin
                $error("point_count: expected %0d, got %0d", want.count, got_count);
                mismatch_count++;
            end
            if (got_complete !== want.complete) begin
                $error("set_complete: expected %0d, got %0d", want.complete, got_complete);
                mismatch_count++;
            end
        end
    endtask

    // Result side: random back-pressure plus one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid)
                check_result(m_tdata);
        end
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: reset, directed script, then random phases
    initial begin
        script_row_t row;
        int          random_sent;
        int          phase;
        int          run_len;
        logic        c;
        logic [7:0]  px, py;
        random_sent = 0;
        phase       = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            row = script[k];
            case (row.kind)
                ROW_CFG:   write_target(row.cfg);
                ROW_CLEAR: send_word(1'b1, row.x, row.y, row.typed, row.want);
                default:   send_word(1'b0, row.x, row.y, row.typed, row.want);
            endcase
        end

        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            quiet = (random_sent >= RANDOM_ITEMS - QUIET_TAIL);
            if (!quiet && phase % 3 == 0)
                write_target(pick_target());
            else if (!quiet && $urandom_range(0, 4) == 0)
                drain_results();
            if (phase == 6)
                hold_req = 1'b1;
            ox = $urandom_range(0, 240);
            oy = $urandom_range(0, 30);
            if ($urandom_range(0, 4) != 0) begin
                send_word(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, '0);
                random_sent++;
            end
            run_len = $urandom_range(8, 40);
            repeat (run_len) begin
                pick_candidate(c, px, py);
                send_word(c, px, py, 1'b0, '0);
                random_sent++;
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
